// ===== rtl/core/baf_pkg.sv =====
// package for the bitmap first-fit block allocator
// shared widths, the queued command type and default sizes; no dependencies
`timescale 1ns / 1ps

package baf_pkg;

  localparam int BLOCKS_DEF = 1024;
  localparam int CNT_W      = 17;
  localparam int WORD_W     = 8;
  localparam int BYTES_W    = 26;
  localparam int ADDR_W     = 32;
  localparam int BB_W       = 16;
  localparam logic [BYTES_W-1:0] USED_MAX = {BYTES_W{1'b1}};

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  localparam logic [1:0] REG_BLOCK_BYTES = 2'd0;
  localparam logic [1:0] REG_HEAP_BASE   = 2'd1;

  typedef struct packed {
    logic               is_free;
    logic               fail;
    logic [BYTES_W-1:0] bytes;
    logic [CNT_W-1:0]   cnt;
    logic [CNT_W-1:0]   lo;
    logic [CNT_W-1:0]   hi;
  } cmd_t;

endpackage

// ===== rtl/core/bitmap_first_fit_block_allocator.sv =====
// bitmap first-fit block allocator, top level with configuration registers
// depends on baf_pkg, baf_front, baf_cmdq, baf_back
//
// channel   ports                                   handshake
// input     in_action in_request_bytes in_free_address  push / full
// result    out_status out_block_address out_used_bytes  empty / pop
// config    paddr pwdata prdata                     psel penable pwrite pready
//
// front end: each request runs through a bit-a-cycle divider (one divide for
// allocate, two for a free at or above the heap base), then a two-entry queue
// back end: allocate scans 8 map bits a cycle, one word per cycle, then reads and
// writes each map word marked; a full scan of BLOCKS/8 words sets the worst case
// after reset the whole map is cleared, word by word, before the first request runs
// a waiting result stalls the back end; the front end keeps accepting until the queue fills
`timescale 1ns / 1ps

module bitmap_first_fit_block_allocator import baf_pkg::*; #(
  parameter int BLOCKS = BLOCKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_action,
  input  logic [BYTES_W-1:0] in_request_bytes,
  input  logic [ADDR_W-1:0]  in_free_address,
  output logic               empty,
  input  logic               pop,
  output logic               out_status,
  output logic [ADDR_W-1:0]  out_block_address,
  output logic [BYTES_W-1:0] out_used_bytes,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [BB_W-1:0]   block_bytes_r;
  logic [ADDR_W-1:0] heap_base_r;
  logic [BB_W-1:0]   eff;
  logic [1:0]        reg_idx;
  logic              q_push, q_pop, q_full, q_empty;
  cmd_t              q_wcmd, q_rcmd;

  assign pready  = 1'b1;
  assign reg_idx = {1'b0, paddr[2]};
  assign eff     = (block_bytes_r == '0) ? BB_W'(1) : block_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_bytes_r <= BB_W'(16);
      heap_base_r   <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_BLOCK_BYTES: block_bytes_r <= pwdata[BB_W-1:0];
        REG_HEAP_BASE:   heap_base_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BLOCK_BYTES: prdata = 32'(block_bytes_r);
      REG_HEAP_BASE:   prdata = heap_base_r;
      default:         prdata = '0;
    endcase
  end

  baf_front #(.BLOCKS(BLOCKS)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .eff              (eff),
    .base             (heap_base_r),
    .push             (push),
    .full             (full),
    .in_action        (in_action),
    .in_request_bytes (in_request_bytes),
    .in_free_address  (in_free_address),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (q_wcmd)
  );

  baf_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wcmd  (q_wcmd),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_rcmd  (q_rcmd),
    .q_empty (q_empty)
  );

  baf_back #(.BLOCKS(BLOCKS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .eff               (eff),
    .base              (heap_base_r),
    .q_empty           (q_empty),
    .q_cmd             (q_rcmd),
    .q_pop             (q_pop),
    .empty             (empty),
    .pop               (pop),
    .out_status        (out_status),
    .out_block_address (out_block_address),
    .out_used_bytes    (out_used_bytes)
  );

endmodule

// ===== rtl/core/baf_ram.sv =====
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module baf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
  input  logic [WIDTH-1:0]                        wdata,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/baf_front.sv =====
// request front end: block count and free index by a shared serial divider
// depends on baf_pkg
`timescale 1ns / 1ps

module baf_front import baf_pkg::*; #(
  parameter int BLOCKS = BLOCKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [BB_W-1:0]    eff,
  input  logic [ADDR_W-1:0]  base,
  input  logic               push,
  output logic               full,
  input  logic               in_action,
  input  logic [BYTES_W-1:0] in_request_bytes,
  input  logic [ADDR_W-1:0]  in_free_address,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_cmd
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_DIV1 = 4'b0010,
    F_DIV2 = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t             state_r, state_nxt;
  logic [31:0]         acc_r, acc_nxt;
  logic [BB_W:0]       rem_r, rem_nxt;
  logic [4:0]          dcnt_r, dcnt_nxt;
  logic                free_r;
  logic                below_r;
  logic [BYTES_W-1:0]  bytes_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [BYTES_W:0]    cntf_r;
  logic [31:0]         first_r;
  logic [BB_W:0]       rem_s;
  logic                qbit;
  logic [32:0]         hsum;
  logic                fvalid;

  assign full = (state_r != F_IDLE);

  always_comb begin
    rem_s   = {rem_r[BB_W-1:0], acc_r[31]};
    qbit    = (rem_s >= {1'b0, eff});
    rem_nxt = qbit ? rem_s - {1'b0, eff} : rem_s;
    acc_nxt = {acc_r[30:0], qbit};
    dcnt_nxt = dcnt_r + 5'd1;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (push) state_nxt = F_DIV1;
      F_DIV1: if (dcnt_r == 5'd31) state_nxt = (free_r && !below_r) ? F_DIV2 : F_PUSH;
      F_DIV2: if (dcnt_r == 5'd31) state_nxt = F_PUSH;
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_DIV1 || state_r == F_DIV2) dcnt_r <= dcnt_nxt;
      else dcnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (push) begin
          free_r  <= in_action;
          bytes_r <= in_request_bytes;
          addr_r  <= in_free_address;
          below_r <= (in_free_address < base);
          acc_r   <= 32'(in_request_bytes) + 32'(eff) - 32'd1;
          rem_r   <= '0;
        end
      end
      F_DIV1: begin
        if (dcnt_r == 5'd31) begin
          cntf_r  <= acc_nxt[BYTES_W:0];
          acc_r   <= addr_r - base;
          rem_r   <= '0;
          first_r <= '0;
        end else begin
          acc_r <= acc_nxt;
          rem_r <= rem_nxt;
        end
      end
      F_DIV2: begin
        acc_r <= acc_nxt;
        rem_r <= rem_nxt;
        if (dcnt_r == 5'd31) first_r <= acc_nxt;
      end
      default: ;
    endcase
  end

  always_comb begin
    hsum   = {1'b0, first_r} + 33'(cntf_r);
    fvalid = !below_r && (first_r < 32'(BLOCKS));
    q_push = (state_r == F_PUSH) && !q_full;
    q_cmd.is_free = free_r;
    q_cmd.fail    = !free_r && (cntf_r > (BYTES_W+1)'(BLOCKS));
    q_cmd.bytes   = bytes_r;
    q_cmd.cnt     = cntf_r[CNT_W-1:0];
    q_cmd.lo      = '0;
    q_cmd.hi      = '0;
    if (free_r && fvalid) begin
      q_cmd.lo = first_r[CNT_W-1:0];
      q_cmd.hi = (hsum > 33'(BLOCKS)) ? CNT_W'(BLOCKS) : hsum[CNT_W-1:0];
    end
  end

endmodule

// ===== rtl/core/baf_cmdq.sv =====
// two-entry command queue between front end and back end
// depends on baf_pkg
`timescale 1ns / 1ps

module baf_cmdq import baf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_push,
  input  cmd_t q_wcmd,
  output logic q_full,
  input  logic q_pop,
  output cmd_t q_rcmd,
  output logic q_empty
);

  cmd_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign q_rcmd  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (q_push) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(q_push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) ent_r[wp_r] <= q_wcmd;
  end

endmodule

// ===== rtl/core/baf_back.sv =====
// back end: map clearing, first-fit scan, run marking and result register
// depends on baf_pkg and baf_ram
`timescale 1ns / 1ps

module baf_back import baf_pkg::*; #(
  parameter int BLOCKS = BLOCKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [BB_W-1:0]    eff,
  input  logic [ADDR_W-1:0]  base,
  input  logic               q_empty,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic               out_status,
  output logic [ADDR_W-1:0]  out_block_address,
  output logic [BYTES_W-1:0] out_used_bytes
);

  localparam int WORDS = (BLOCKS + WORD_W - 1) / WORD_W;
  localparam int AW    = $clog2(WORDS > 1 ? WORDS : 2);

  typedef enum logic [6:0] {
    B_CLR  = 7'b0000001,
    B_IDLE = 7'b0000010,
    B_SCAN = 7'b0000100,
    B_MRD  = 7'b0001000,
    B_MWR  = 7'b0010000,
    B_MUL  = 7'b0100000,
    B_DONE = 7'b1000000
  } bstate_t;

  bstate_t             state_r, state_nxt;
  cmd_t                cmd_r;
  logic [AW:0]         clr_r, iss_r;
  logic                dv_r;
  logic [AW-1:0]       word_r, mw_r;
  logic [CNT_W-1:0]    run_r, lo_r, hi_r;
  logic                fail_r;
  logic [31:0]         prod_r;
  logic [BYTES_W-1:0]  used_r;
  logic                out_vld_r;
  logic                out_st_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;
  logic [CNT_W-1:0]    run_w, endi_w, idx_j, start_w;
  logic [CNT_W-1:0]    idx_m;
  logic                fnd_w;
  logic [AW-1:0]       mlast;
  logic [CNT_W-1:0]    hm1;
  logic                out_free;
  logic [BYTES_W:0]    usum;

  baf_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    run_w  = run_r;
    fnd_w  = 1'b0;
    endi_w = '0;
    idx_j  = '0;
    for (int j = 0; j < WORD_W; j++) begin
      idx_j = CNT_W'(word_r) * CNT_W'(WORD_W) + CNT_W'(j);
      if (!fnd_w) begin
        if (ram_rdata[j] || idx_j >= CNT_W'(BLOCKS)) begin
          run_w = '0;
        end else begin
          run_w = run_w + CNT_W'(1);
          if (run_w == cmd_r.cnt) begin
            fnd_w  = 1'b1;
            endi_w = idx_j;
          end
        end
      end
    end
    start_w = endi_w - cmd_r.cnt + CNT_W'(1);
  end

  always_comb begin
    hm1       = hi_r - CNT_W'(1);
    mlast     = AW'(hm1 / CNT_W'(WORD_W));
    ram_we    = 1'b0;
    ram_addr  = mw_r;
    ram_wdata = ram_rdata;
    idx_m     = '0;
    case (state_r)
      B_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r[AW-1:0];
        ram_wdata = '0;
      end
      B_SCAN: ram_addr = iss_r[AW-1:0];
      B_MWR: begin
        ram_we = 1'b1;
        for (int j = 0; j < WORD_W; j++) begin
          idx_m = CNT_W'(mw_r) * CNT_W'(WORD_W) + CNT_W'(j);
          if (idx_m >= lo_r && idx_m < hi_r) ram_wdata[j] = !cmd_r.is_free;
        end
      end
      default: ;
    endcase
  end

  assign out_free = pop && out_vld_r;
  assign q_pop    = (state_r == B_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_CLR: if (clr_r == (AW+1)'(WORDS - 1)) state_nxt = B_IDLE;
      B_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.is_free) state_nxt = (q_cmd.lo < q_cmd.hi) ? B_MRD : B_DONE;
          else if (q_cmd.fail) state_nxt = B_DONE;
          else if (q_cmd.cnt == '0) state_nxt = B_MUL;
          else state_nxt = B_SCAN;
        end
      end
      B_SCAN: begin
        if (dv_r && fnd_w) state_nxt = B_MRD;
        else if (dv_r && word_r == AW'(WORDS - 1)) state_nxt = B_DONE;
      end
      B_MRD: state_nxt = B_MWR;
      B_MWR: begin
        if (mw_r == mlast) state_nxt = cmd_r.is_free ? B_DONE : B_MUL;
        else state_nxt = B_MRD;
      end
      B_MUL: state_nxt = B_DONE;
      B_DONE: if (!out_vld_r || out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_CLR;
      clr_r     <= '0;
      used_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_CLR) clr_r <= clr_r + (AW+1)'(1);
      if (state_r == B_DONE && (!out_vld_r || out_free)) begin
        out_vld_r <= 1'b1;
        if (cmd_r.is_free) begin
          used_r <= (used_r > cmd_r.bytes) ? used_r - cmd_r.bytes : '0;
        end else if (!fail_r) begin
          used_r <= usum[BYTES_W] ? USED_MAX : usum[BYTES_W-1:0];
        end
      end else if (out_free) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign usum = {1'b0, used_r} + {1'b0, cmd_r.bytes};

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        cmd_r  <= q_cmd;
        fail_r <= q_cmd.fail;
        lo_r   <= q_cmd.lo;
        hi_r   <= q_cmd.hi;
        mw_r   <= AW'(q_cmd.lo / CNT_W'(WORD_W));
        iss_r  <= '0;
        dv_r   <= 1'b0;
        run_r  <= '0;
      end
      B_SCAN: begin
        dv_r   <= (iss_r < (AW+1)'(WORDS));
        word_r <= iss_r[AW-1:0];
        if (iss_r < (AW+1)'(WORDS)) iss_r <= iss_r + (AW+1)'(1);
        if (dv_r) begin
          run_r <= run_w;
          if (fnd_w) begin
            lo_r <= start_w;
            hi_r <= endi_w + CNT_W'(1);
            mw_r <= AW'(start_w / CNT_W'(WORD_W));
          end else if (word_r == AW'(WORDS - 1)) begin
            fail_r <= 1'b1;
          end
        end
      end
      B_MWR: mw_r <= mw_r + AW'(1);
      B_MUL: prod_r <= 32'(lo_r) * 32'(eff);
      B_DONE: begin
        if (!out_vld_r || out_free) begin
          out_st_r   <= (!cmd_r.is_free && fail_r) ? ST_FULL : ST_OK;
          out_addr_r <= (cmd_r.is_free || fail_r) ? '0 : base + prod_r;
        end
      end
      default: ;
    endcase
  end

  assign empty             = !out_vld_r;
  assign out_status        = out_st_r;
  assign out_block_address = out_addr_r;
  assign out_used_bytes    = used_r;

  a_we_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == B_CLR || state_r == B_MWR))
    else $error("map written outside clear or mark");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == B_DONE))
    else $error("result appeared without completion");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r != B_IDLE && state_r != B_CLR))
    else $error("command taken but back end not busy");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !pop) |=> (out_vld_r && $stable(out_addr_r)))
    else $error("waiting result changed");

endmodule

// ===== tb/bitmap_first_fit_block_allocator_test.sv =====
// testbench for the bitmap first-fit block allocator: random and directed requests
// checked against a behavioral model of the map in a small scoreboard class
// depends on baf_pkg and bitmap_first_fit_block_allocator
`timescale 1ns / 1ps

module bitmap_first_fit_block_allocator_test;
  import baf_pkg::*;

  localparam int NBLK = 1024;
  localparam int RAND_ITEMS = 1520;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic               status;
    logic [ADDR_W-1:0]  addr;
    logic [BYTES_W-1:0] used;
  } alloc_result_t;

  class alloc_scoreboard;
    bit [NBLK-1:0] map;
    logic [BB_W-1:0] blk_bytes;
    logic [ADDR_W-1:0] base;
    logic [BYTES_W-1:0] used;
    alloc_result_t pending[$];
    int errors;

    function void reset_state();
      map = '0;
      blk_bytes = BB_W'(16);
      base = '0;
      used = '0;
      pending.delete();
      errors = 0;
    endfunction

    function void note_request(logic act, logic [BYTES_W-1:0] bytes, logic [ADDR_W-1:0] fa);
      longint unsigned eb, cnt, run, start, first, last, sum;
      bit found;
      alloc_result_t r;
      eb = (blk_bytes == 0) ? 1 : blk_bytes;
      cnt = (longint'(bytes) + eb - 1) / eb;
      r = '0;
      if (act == ACT_ALLOC) begin
        found = 0;
        start = 0;
        run = 0;
        if (cnt == 0) found = 1;
        else if (cnt <= NBLK) begin
          for (int i = 0; i < NBLK; i++) begin
            if (map[i]) run = 0;
            else begin
              run++;
              if (run == cnt) begin
                start = i + 1 - cnt;
                found = 1;
                break;
              end
            end
          end
        end
        if (found) begin
          for (longint unsigned i = 0; i < cnt; i++) map[start + i] = 1'b1;
          sum = longint'(used) + longint'(bytes);
          used = (sum > longint'(USED_MAX)) ? USED_MAX : sum[BYTES_W-1:0];
          r.addr = ADDR_W'(longint'(base) + start * eb);
        end else begin
          r.status = ST_FULL;
        end
      end else begin
        if (fa >= base) begin
          first = (longint'(fa) - longint'(base)) / eb;
          last = first + cnt;
          if (last > NBLK) last = NBLK;
          for (longint unsigned i = first; i < last; i++) map[i] = 1'b0;
        end
        used = (used > bytes) ? used - bytes : '0;
      end
      r.used = used;
      pending.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.addr !== exp.addr) begin
        $display("%0t: block_address expected %h actual %h", $time, exp.addr, got.addr);
        errors++;
      end
      if (got.used !== exp.used) begin
        $display("%0t: used_bytes expected %0d actual %0d", $time, exp.used, got.used);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, push, full, in_action, empty, pop, out_status;
  logic [BYTES_W-1:0] in_request_bytes, out_used_bytes;
  logic [ADDR_W-1:0] in_free_address, out_block_address;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  alloc_scoreboard sb;
  int push_idle_pct, pop_idle_pct;
  longint cycles;

  bitmap_first_fit_block_allocator uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("bitmap_first_fit_block_allocator_test: FAIL");
        $finish;
      end
    end
  end

  // result side: random stall, check on each transfer
  always @(posedge clk) begin
    if (rst_n && pop && !empty)
      sb.check_result('{out_status, out_block_address, out_used_bytes});
    pop <= ($urandom_range(99) >= pop_idle_pct);
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx[0], 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == REG_BLOCK_BYTES) sb.blk_bytes = val[BB_W-1:0];
    else sb.base = val;
    @(posedge clk);
  endtask

  task automatic send_request(logic act, logic [BYTES_W-1:0] bytes, logic [ADDR_W-1:0] fa);
    while ($urandom_range(99) < push_idle_pct) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    in_action <= act; in_request_bytes <= bytes; in_free_address <= fa;
    do @(posedge clk); while (full);
    sb.note_request(act, bytes, fa);
  endtask

  task automatic wait_drain();
    push <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // mostly sizes of up to 24 blocks, frees mostly of block-aligned addresses near the heap base
  task automatic random_request();
    logic [BYTES_W-1:0] bytes;
    logic [ADDR_W-1:0] fa;
    int unsigned eb, k;
    eb = (sb.blk_bytes == 0) ? 1 : sb.blk_bytes;
    k = $urandom_range(99);
    if (k < 50) bytes = BYTES_W'($urandom_range(eb * 24));
    else if (k < 55) bytes = BYTES_W'($urandom);
    else bytes = BYTES_W'($urandom_range(eb * 4));
    fa = sb.base + $urandom_range(NBLK + 8) * eb;
    if ($urandom_range(9) == 0) fa = $urandom;
    send_request($urandom_range(99) < 45, bytes, fa);
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    rst_n = 0; push = 0; pop = 0; in_action = 0; in_request_bytes = 0; in_free_address = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    push_idle_pct = 23; pop_idle_pct = 88;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes and special cases, first under reset config, then with other block sizes and bases
    send_request(ACT_ALLOC, 0, 0);
    send_request(ACT_ALLOC, 1, 0);
    send_request(ACT_ALLOC, 16 * NBLK, 0);
    send_request(ACT_ALLOC, USED_MAX, '1);
    send_request(ACT_ALLOC, 16 * 1022, 0);
    send_request(ACT_ALLOC, 33, 0);
    send_request(ACT_FREE, 16, 37);
    send_request(ACT_FREE, USED_MAX, 32'hFFFF_FFFF);
    send_request(ACT_FREE, 16 * NBLK, 0);
    send_request(ACT_FREE, 0, 0);
    wait_drain();
    write_reg(REG_BLOCK_BYTES, 0);
    write_reg(REG_HEAP_BASE, 32'hFFFF_FF00);
    send_request(ACT_ALLOC, NBLK, 0);
    send_request(ACT_FREE, 5, 32'h0000_0010);
    send_request(ACT_FREE, 3, 32'hFFFF_FFFF);
    send_request(ACT_FREE, 4, 32'hFFFF_FF10);
    send_request(ACT_ALLOC, 300, 0);
    wait_drain();
    write_reg(REG_BLOCK_BYTES, 16'hFFFF);
    write_reg(REG_HEAP_BASE, 32'h8000_0000);
    send_request(ACT_ALLOC, USED_MAX, 0);
    send_request(ACT_ALLOC, USED_MAX, 0);
    send_request(ACT_FREE, 1, 32'h7FFF_FFFF);
    send_request(ACT_FREE, USED_MAX, 32'h8000_0000);
    send_request(ACT_FREE, 1, 32'hFFFF_FFFF);

    for (int ph = 0; ph < 6; ph++) begin
      wait_drain();
      if (ph == 2) begin push_idle_pct = 88; pop_idle_pct = 23; end
      if (ph == 4) begin push_idle_pct = 0; pop_idle_pct = 0; end
      case (ph)
        0: write_reg(REG_BLOCK_BYTES, 1);
        1: write_reg(REG_BLOCK_BYTES, 16);
        2: write_reg(REG_BLOCK_BYTES, $urandom_range(2, 700));
        3: write_reg(REG_BLOCK_BYTES, 16'hFFFF);
        4: write_reg(REG_BLOCK_BYTES, 64);
        default: write_reg(REG_BLOCK_BYTES, 0);
      endcase
      write_reg(REG_HEAP_BASE, (ph == 3) ? 32'hFFFF_0000 : $urandom);
      for (int i = 0; i < RAND_ITEMS / 6; i++) random_request();
    end

    wait_drain();
    if (sb.errors == 0)
      $display("bitmap_first_fit_block_allocator_test: PASS");
    else
      $display("bitmap_first_fit_block_allocator_test: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/baf_pkg.sv
rtl/core/baf_ram.sv
rtl/core/baf_front.sv
rtl/core/baf_cmdq.sv
rtl/core/baf_back.sv
rtl/core/bitmap_first_fit_block_allocator.sv
tb/bitmap_first_fit_block_allocator_test.sv
